// ===== hdl/ttint_pkg.sv =====
// Shared types and constants for the timed track interpolator.
package ttint_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int TIME_W  = 48;
  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int COUNT_W = 9;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_INTERP = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0]  sample_time;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } entry_t;

endpackage

// ===== hdl/ttint_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ttint_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/timed_track_interpolator.sv =====
// Timed track interpolator: sorted point table with linear interpolation.
//
// Input channel (in_valid / in_stall) carries one item: an opcode (clear,
// insert, interpolate), a 32.16 time and a signed 16.16 point. Result
// channel (out_valid / out_stall) returns exactly one item per input item:
// status, interpolated x/y/z and the number of points held afterwards.
// Points live in one RAM word per entry, kept sorted by time; equal times
// go after existing ones.
// Items are handled one at a time; in_stall is high while one is in work.
// Work per item:
//   clear: count set to zero; insert: linear scan, then shift of the tail
//   (one RAM read and one write per moved entry);
//   interpolate: scan, neighbor read, 16-bit restoring divide, then one
//   33x17 multiply and add per axis; an exact time match skips the math.
// The single RAM read port sets the scan and shift rates.
// A finished result sits in the output register until taken; the next item
// is accepted while it waits, and its result waits for that slot.
// Synchronous active-low reset empties the table (count to zero); table
// contents are not cleared and entries beyond the count are never used.
module timed_track_interpolator #(
  parameter int TABLE_DEPTH = ttint_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_opcode,
  input  logic [ttint_pkg::TIME_W-1:0]     in_sample_time,
  input  logic signed [ttint_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [ttint_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [ttint_pkg::COORD_W-1:0] in_pos_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic signed [ttint_pkg::COORD_W-1:0] out_x,
  output logic signed [ttint_pkg::COORD_W-1:0] out_y,
  output logic signed [ttint_pkg::COORD_W-1:0] out_z,
  output logic [ttint_pkg::COUNT_W-1:0]    out_entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int TW = ttint_pkg::TIME_W;
  localparam int XW = ttint_pkg::COORD_W;
  localparam int FW = ttint_pkg::FRAC_W;
  localparam int PW = XW + FW + 2;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SCAN_RD  = 10'b0000000010,
    S_SCAN_CHK = 10'b0000000100,
    S_SHIFT_RD = 10'b0000001000,
    S_SHIFT_WR = 10'b0000010000,
    S_LO_RD    = 10'b0000100000,
    S_LO_CHK   = 10'b0001000000,
    S_DIV      = 10'b0010000000,
    S_MUL      = 10'b0100000000,
    S_ACC      = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]              op_r;
  ttint_pkg::entry_t       new_r;
  ttint_pkg::entry_t       hi_r, lo_r;
  ttint_pkg::entry_t       rd_data;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           sh_r, sh_nxt;
  logic [TW-1:0]           rem_r, div_d_r;
  logic [FW-1:0]           frac_r;
  logic [4:0]              step_r;
  logic [1:0]              axis_r;
  logic signed [PW-1:0]    prod_r;
  logic [XW-1:0]           res_r [3];
  logic [1:0]              res_status_r;
  logic                    done_r;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  ttint_pkg::entry_t       wr_data;
  logic [AW-1:0]           rd_addr;

  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic [XW-1:0]           out_x_r, out_y_r, out_z_r;
  logic [ttint_pkg::COUNT_W-1:0] out_count_r;

  logic                    in_take;
  logic                    slot_free;
  logic                    scan_go;
  logic [TW:0]             rem2;
  logic [XW-1:0]           a_sel, b_sel;
  logic signed [XW:0]      diff;

  assign in_stall  = (state_r != S_IDLE) || done_r;
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign scan_go = (op_r == ttint_pkg::OP_INSERT) ? (rd_data.sample_time <= new_r.sample_time)
                                                  : (rd_data.sample_time <  new_r.sample_time);
  assign rem2 = {rem_r, 1'b0};

  always_comb begin
    case (axis_r)
      2'd0:    begin a_sel = lo_r.x; b_sel = hi_r.x; end
      2'd1:    begin a_sel = lo_r.y; b_sel = hi_r.y; end
      default: begin a_sel = lo_r.z; b_sel = hi_r.z; end
    endcase
  end
  assign diff = $signed({b_sel[XW-1], b_sel}) - $signed({a_sel[XW-1], a_sel});

  always_comb begin
    rd_addr = idx_r[AW-1:0];
    case (state_r)
      S_SHIFT_RD: rd_addr = AW'(sh_r - CW'(1));
      S_LO_RD:    rd_addr = AW'(idx_r - CW'(1));
      default:    rd_addr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sh_r[AW-1:0];
    wr_data = rd_data;
    if (state_r == S_SHIFT_WR) begin
      wr_en = 1'b1;
    end else if (state_r == S_SHIFT_RD && sh_r == idx_r) begin
      wr_en   = 1'b1;
      wr_addr = idx_r[AW-1:0];
      wr_data = new_r;
    end
  end

  ttint_ram #(
    .WIDTH($bits(ttint_pkg::entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    sh_nxt    = sh_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          idx_nxt = '0;
          if (in_opcode == ttint_pkg::OP_INSERT) begin
            if (count_r < DEPTH_C) begin
              state_nxt = S_SCAN_RD;
            end
          end else if (in_opcode == ttint_pkg::OP_QUERY) begin
            state_nxt = S_SCAN_RD;
          end else if (in_opcode == ttint_pkg::OP_CLEAR) begin
            count_nxt = '0;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          sh_nxt    = count_r;
          state_nxt = (op_r == ttint_pkg::OP_INSERT) ? S_SHIFT_RD : S_IDLE;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (scan_go) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SCAN_RD;
        end else if (op_r == ttint_pkg::OP_INSERT) begin
          sh_nxt    = count_r;
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = (idx_r == '0) ? S_IDLE : S_LO_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sh_r == idx_r) begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        sh_nxt    = sh_r - CW'(1);
        state_nxt = S_SHIFT_RD;
      end
      S_LO_RD:  state_nxt = S_LO_CHK;
      S_LO_CHK: state_nxt = (new_r.sample_time == hi_r.sample_time) ? S_IDLE : S_DIV;
      S_DIV:    state_nxt = (step_r == 5'd15) ? S_MUL : S_DIV;
      S_MUL:    state_nxt = S_ACC;
      S_ACC:    state_nxt = (axis_r == 2'd2) ? S_IDLE : S_MUL;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      // result finished on return to idle, or when a taken item needs no work
      if (state_r != S_IDLE && state_nxt == S_IDLE) begin
        done_r <= 1'b1;
      end else if (in_take && state_nxt == S_IDLE) begin
        done_r <= 1'b1;
      end else if (done_r && slot_free) begin
        done_r <= 1'b0;
      end
      if (done_r && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sh_r  <= sh_nxt;
    if (in_take) begin
      op_r              <= in_opcode;
      new_r.sample_time <= in_sample_time;
      new_r.x           <= in_pos_x;
      new_r.y           <= in_pos_y;
      new_r.z           <= in_pos_z;
      res_r[0]          <= '0;
      res_r[1]          <= '0;
      res_r[2]          <= '0;
      axis_r            <= '0;
      step_r            <= '0;
      res_status_r      <= (in_opcode == ttint_pkg::OP_INSERT && count_r >= DEPTH_C)
                           ? ttint_pkg::ST_FULL : ttint_pkg::ST_DONE;
    end
    case (state_r)
      S_SCAN_RD: begin
        if (idx_r == count_r && op_r != ttint_pkg::OP_INSERT) begin
          res_status_r <= ttint_pkg::ST_MISS;
        end
      end
      S_SCAN_CHK: begin
        hi_r <= rd_data;
        if (!scan_go && op_r != ttint_pkg::OP_INSERT && idx_r == '0) begin
          res_status_r <= ttint_pkg::ST_MISS;
        end
      end
      S_LO_CHK: begin
        lo_r         <= rd_data;
        res_status_r <= ttint_pkg::ST_INTERP;
        rem_r        <= new_r.sample_time - rd_data.sample_time;
        div_d_r      <= hi_r.sample_time - rd_data.sample_time;
        frac_r       <= '0;
        if (new_r.sample_time == hi_r.sample_time) begin
          res_r[0] <= hi_r.x;
          res_r[1] <= hi_r.y;
          res_r[2] <= hi_r.z;
        end
      end
      S_DIV: begin
        step_r <= step_r + 5'd1;
        if (rem2 >= {1'b0, div_d_r}) begin
          rem_r  <= TW'(rem2 - {1'b0, div_d_r});
          frac_r <= {frac_r[FW-2:0], 1'b1};
        end else begin
          rem_r  <= rem2[TW-1:0];
          frac_r <= {frac_r[FW-2:0], 1'b0};
        end
      end
      S_MUL: begin
        prod_r <= PW'($signed({1'b0, frac_r}) * diff);
      end
      S_ACC: begin
        res_r[axis_r] <= a_sel + prod_r[XW+FW-1:FW];
        axis_r        <= axis_r + 2'd1;
      end
      default: ;
    endcase
    if (done_r && slot_free) begin
      out_status_r <= res_status_r;
      out_x_r      <= res_r[0];
      out_y_r      <= res_r[1];
      out_z_r      <= res_r[2];
      out_count_r  <= ttint_pkg::COUNT_W'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_z           = out_z_r;
  assign out_entry_count = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("entry count beyond table depth");
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");
  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_RD || state_r == S_SHIFT_WR) |-> (sh_r >= idx_r && sh_r <= count_r))
    else $error("shift pointer outside insert range");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done_r)) else $error("result shown without finished item");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en) else $error("table written while idle");
`endif

endmodule
